@@ hw/rtl/rcpd_pkg.sv @@
// Shared types and constants for the RC channel press detector.
package rcpd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int SIG_W    = 12;
    localparam int PERIOD_W = 32;
    localparam int TIME_W   = 32;
    localparam int THR_W    = SIG_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_PERIOD = 2'd3;

    localparam logic [SIG_W-1:0]    RST_SIGNAL_MIN   = 12'd1000;
    localparam logic [SIG_W-1:0]    RST_SIGNAL_MAX   = 12'd2000;
    localparam logic                RST_PRESS_MODE   = 1'b0;
    localparam logic [PERIOD_W-1:0] RST_PRESS_PERIOD = 32'd1000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FETCH  = 1'b1;

    localparam logic MODE_LONG  = 1'b0;
    localparam logic MODE_SHORT = 1'b1;

    typedef struct packed {
        logic [SIG_W-1:0]        signal_min;
        logic [SIG_W-1:0]        signal_max;
        logic                    press_mode;
        logic [PERIOD_W-1:0]     press_period;
        logic signed [THR_W-1:0] threshold;
    } t_cfg;

endpackage

@@ hw/rtl/rcpd_cfg.sv @@
// Configuration registers and press threshold for the press detector.
module rcpd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rcpd_pkg::t_cfg                   o_cfg
);
    import rcpd_pkg::*;

    logic [SIG_W-1:0]        r_signal_min;
    logic [SIG_W-1:0]        r_signal_max;
    logic                    r_press_mode;
    logic [PERIOD_W-1:0]     r_press_period;
    logic signed [THR_W-1:0] w_diff;
    logic signed [THR_W-1:0] w_quarter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_min   <= RST_SIGNAL_MIN;
            r_signal_max   <= RST_SIGNAL_MAX;
            r_press_mode   <= RST_PRESS_MODE;
            r_press_period <= RST_PRESS_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIGNAL_MIN:   r_signal_min   <= i_cfg_data[SIG_W-1:0];
                CFG_SIGNAL_MAX:   r_signal_max   <= i_cfg_data[SIG_W-1:0];
                CFG_PRESS_MODE:   r_press_mode   <= i_cfg_data[0];
                CFG_PRESS_PERIOD: r_press_period <= i_cfg_data[PERIOD_W-1:0];
            endcase
        end
    end

    // quarter of (max - min), rounded toward zero
    always_comb begin
        w_diff    = $signed({2'b00, r_signal_max}) - $signed({2'b00, r_signal_min});
        w_quarter = (w_diff < 0) ? ((w_diff + THR_W'(3)) >>> 2) : (w_diff >>> 2);
    end

    assign o_cfg.signal_min   = r_signal_min;
    assign o_cfg.signal_max   = r_signal_max;
    assign o_cfg.press_mode   = r_press_mode;
    assign o_cfg.press_period = r_press_period;
    assign o_cfg.threshold    = $signed({2'b00, r_signal_max}) - w_quarter;

endmodule

@@ hw/rtl/rcpd_core.sv @@
// Press state and event decision for one staged request.
module rcpd_core #(
    parameter int SAMPLE_BITS = rcpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_opcode,
    input  logic [SAMPLE_BITS-1:0]        i_sample_value,
    input  logic [rcpd_pkg::TIME_W-1:0]   i_now_ms,
    input  rcpd_pkg::t_cfg                i_cfg,
    output logic                          o_event_flag
);
    import rcpd_pkg::*;

    localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

    logic              r_pressed;
    logic [TIME_W-1:0] r_start;
    logic              r_reported;
    logic              r_pending;
    logic              n_pressed;
    logic [TIME_W-1:0] n_start;
    logic              n_reported;
    logic              n_pending;
    logic              w_now_pressed;
    logic [TIME_W-1:0] w_held;
    logic signed [CMP_W-1:0] w_sample_ext;
    logic signed [CMP_W-1:0] w_thr_ext;

    assign w_sample_ext  = $signed({{(CMP_W-SAMPLE_BITS){1'b0}}, i_sample_value});
    assign w_thr_ext     = CMP_W'(i_cfg.threshold);
    assign w_now_pressed = w_sample_ext > w_thr_ext;
    assign w_held        = i_now_ms - r_start;

    always_comb begin
        n_pressed    = r_pressed;
        n_start      = r_start;
        n_reported   = r_reported;
        n_pending    = r_pending;
        o_event_flag = 1'b0;
        if (i_opcode == OP_FETCH) begin
            o_event_flag = r_pending;
            n_pending    = 1'b0;
        end else if (i_sample_value != '0) begin
            if (w_now_pressed && !r_pressed) begin
                n_start = i_now_ms;
            end else if (!r_reported && r_pressed) begin
                if (i_cfg.press_mode == MODE_LONG) begin
                    if (w_held >= i_cfg.press_period) begin
                        n_pending  = 1'b1;
                        n_reported = 1'b1;
                    end
                end else if (!w_now_pressed && (w_held < i_cfg.press_period)) begin
                    n_pending = 1'b1;
                end
            end
            if (r_pressed != w_now_pressed) begin
                n_reported = 1'b0;
            end
            n_pressed = w_now_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed  <= 1'b0;
            r_start    <= '0;
            r_reported <= 1'b0;
            r_pending  <= 1'b0;
        end else if (i_advance) begin
            r_pressed  <= n_pressed;
            r_start    <= n_start;
            r_reported <= n_reported;
            r_pending  <= n_pending;
        end
    end

endmodule

@@ hw/rtl/rc_channel_press_detector_top.sv @@
// Top level of the RC channel press detector: input stage, core, result stage.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+------------------------------
//   in      | request   | i_in_valid / o_in_ready      | i_opcode, i_sample_value, i_now_ms
//   out     | result    | o_out_valid / i_out_ready    | o_event_flag
//   cfg     | write     | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while results are taken; each request passes the input
// register, then the core logic, then the result register.
// Reset is synchronous, active low, and clears press state and both stage valids.
// A stalled result holds in the result register while one more request waits in
// the input register; the input stops taking requests only when both are full.
module rc_channel_press_detector_top #(
    parameter int SAMPLE_BITS = rcpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_opcode,
    input  logic [SAMPLE_BITS-1:0]           i_sample_value,
    input  logic [rcpd_pkg::TIME_W-1:0]      i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_event_flag,
    input  logic                             i_cfg_we,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcpd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rcpd_pkg::*;

    logic                   r_in_valid;
    logic                   r_opcode;
    logic [SAMPLE_BITS-1:0] r_sample_value;
    logic [TIME_W-1:0]      r_now_ms;
    logic                   r_out_valid;
    logic                   r_event_flag;
    logic                   w_advance;
    logic                   w_flag;
    t_cfg                   w_cfg;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_opcode       <= i_opcode;
            r_sample_value <= i_sample_value;
            r_now_ms       <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_event_flag <= w_flag;
        end
    end

    rcpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rcpd_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_opcode       (r_opcode),
        .i_sample_value (r_sample_value),
        .i_now_ms       (r_now_ms),
        .i_cfg          (w_cfg),
        .o_event_flag   (w_flag)
    );

    assign o_out_valid  = r_out_valid;
    assign o_event_flag = r_event_flag;

endmodule

@@ hw/rtl/rcpd_checker.sv @@
// Port-level checks for the press detector, bound to the top level.
module rcpd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_event_flag
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_event_flag))
        else $error("result changed while stalled");

    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && $past(i_rst_n)
            && $past(o_out_valid && !i_out_ready) && $past(i_in_valid && o_in_ready)
            |-> !o_in_ready)
        else $error("request taken with both stages full");

endmodule

bind rc_channel_press_detector_top rcpd_checker u_rcpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_event_flag (o_event_flag)
);

@@ dv/tb_rc_channel_press_detector_top.sv @@
// Testbench for the RC channel press detector: directed table, then random press sequences.
module tb_rc_channel_press_detector_top;

    import rcpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_ROWS    = 29;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_REQS  = 92;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        bit                    is_cfg;
        logic                  op;
        logic [SIG_W-1:0]      sample;
        logic [TIME_W-1:0]     now;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        logic                  flag;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_opcode = OP_SAMPLE;
    logic [SIG_W-1:0]      i_sample_value = '0;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_event_flag;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SIGNAL_MIN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [SIG_W-1:0]    sig_min_m   = RST_SIGNAL_MIN;
    logic [SIG_W-1:0]    sig_max_m   = RST_SIGNAL_MAX;
    logic                mode_m      = RST_PRESS_MODE;
    logic [PERIOD_W-1:0] period_m    = RST_PRESS_PERIOD;
    logic                held_m      = 1'b0;
    logic [TIME_W-1:0]   start_ms_m  = '0;
    logic                reported_m  = 1'b0;
    logic                pending_m   = 1'b0;

    logic      flag_due_q[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        calm = 1'b0;
    t_stim_row directed_rows [NUM_ROWS];

    rc_channel_press_detector_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_sample_value (i_sample_value),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_flag   (o_event_flag),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int press_threshold();
        int hi;
        int lo;
        hi = int'(sig_max_m);
        lo = int'(sig_min_m);
        return hi - (hi - lo) / 4;
    endfunction

    // advance the press state by one request and return its event flag
    function automatic logic press_event_next(logic op, logic [SIG_W-1:0] sample,
                                              logic [TIME_W-1:0] now);
        logic              flag;
        logic              now_held;
        logic [TIME_W-1:0] held_ms;
        flag = 1'b0;
        if (op == OP_FETCH) begin
            flag = pending_m;
            pending_m = 1'b0;
        end else if (sample != '0) begin
            now_held = int'(sample) > press_threshold();
            if (now_held && !held_m) begin
                start_ms_m = now;
            end else if (!reported_m && held_m) begin
                held_ms = now - start_ms_m;
                if (mode_m == MODE_LONG) begin
                    if (held_ms >= period_m) begin
                        pending_m = 1'b1;
                        reported_m = 1'b1;
                    end
                end else if (!now_held && held_ms < period_m) begin
                    pending_m = 1'b1;
                end
            end
            if (held_m != now_held)
                reported_m = 1'b0;
            held_m = now_held;
        end
        return flag;
    endfunction

    function automatic t_stim_row req_row(logic op, logic [SIG_W-1:0] sample,
                                          logic [TIME_W-1:0] now, bit typed, logic flag);
        t_stim_row r;
        r = '{default: '0};
        r.op = op;
        r.sample = sample;
        r.now = now;
        r.typed = typed;
        r.flag = flag;
        return r;
    endfunction

    function automatic t_stim_row reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [SIG_W-1:0] pick_sample(bit hit);
        int thr;
        thr = press_threshold();
        if (hit && thr < 4095)
            return SIG_W'($urandom_range(thr + 1, 4095));
        if (!hit && thr >= 1)
            return SIG_W'($urandom_range(1, thr));
        return SIG_W'($urandom_range(1, 4095));
    endfunction

    task automatic drain_results();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (flag_due_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_request(logic op, logic [SIG_W-1:0] sample, logic [TIME_W-1:0] now,
                                bit typed, logic flag);
        int   gap;
        logic due;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_sample_value <= sample;
        i_now_ms       <= now;
        do @(posedge i_clk); while (!o_in_ready);
        due = press_event_next(op, sample, now);
        flag_due_q.push_back(typed ? flag : due);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SIGNAL_MIN:   sig_min_m = data[SIG_W-1:0];
            CFG_SIGNAL_MAX:   sig_max_m = data[SIG_W-1:0];
            CFG_PRESS_MODE:   mode_m = data[0];
            CFG_PRESS_PERIOD: period_m = data[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [SIG_W-1:0] lo, logic [SIG_W-1:0] hi, logic mode,
                                 logic [PERIOD_W-1:0] period);
        set_register(CFG_SIGNAL_MIN, CFG_DATA_W'(lo));
        set_register(CFG_SIGNAL_MAX, CFG_DATA_W'(hi));
        set_register(CFG_PRESS_MODE, CFG_DATA_W'(mode));
        set_register(CFG_PRESS_PERIOD, CFG_DATA_W'(period));
    endtask

    // check each result against the oldest pending expectation
    initial begin
        int   stall;
        logic want;
        wait (i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (flag_due_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got event_flag %0b",
                         $time, o_event_flag);
                mismatch_count++;
            end else begin
                want = flag_due_q.pop_front();
                if (o_event_flag !== want) begin
                    $display("%0t: event_flag mismatch, expected %0b, got %0b",
                             $time, want, o_event_flag);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_stim_row         row;
        int                sent;
        int                pick;
        bit                want_press;
        logic [TIME_W-1:0] now_t;
        logic [PERIOD_W-1:0] period;

        directed_rows[0]  = req_row(OP_FETCH, 12'd0, 32'd0, 1'b1, 1'b0);
        directed_rows[1]  = req_row(OP_SAMPLE, 12'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        directed_rows[2]  = req_row(OP_SAMPLE, 12'hFFF, 32'hFFFF_FF00, 1'b1, 1'b0);
        directed_rows[3]  = req_row(OP_SAMPLE, 12'hFFF, 32'h0000_00E7, 1'b1, 1'b0);
        directed_rows[4]  = req_row(OP_SAMPLE, 12'hFFF, 32'h0000_02E8, 1'b1, 1'b0);
        directed_rows[5]  = req_row(OP_FETCH, 12'hFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        directed_rows[6]  = req_row(OP_FETCH, 12'd0, 32'd0, 1'b0, 1'b0);
        directed_rows[7]  = req_row(OP_SAMPLE, 12'd1750, 32'd0, 1'b1, 1'b0);
        directed_rows[8]  = req_row(OP_SAMPLE, 12'd1751, 32'd5, 1'b1, 1'b0);
        directed_rows[9]  = req_row(OP_SAMPLE, 12'd1, 32'd10, 1'b1, 1'b0);
        directed_rows[10] = req_row(OP_FETCH, 12'd0, 32'd0, 1'b0, 1'b0);
        directed_rows[11] = reg_row(CFG_SIGNAL_MIN, 32'd4095);
        directed_rows[12] = reg_row(CFG_SIGNAL_MAX, 32'd0);
        directed_rows[13] = reg_row(CFG_PRESS_PERIOD, 32'd0);
        directed_rows[14] = req_row(OP_SAMPLE, 12'd1023, 32'd20, 1'b1, 1'b0);
        directed_rows[15] = req_row(OP_SAMPLE, 12'd1024, 32'd30, 1'b1, 1'b0);
        directed_rows[16] = req_row(OP_SAMPLE, 12'd1024, 32'd30, 1'b1, 1'b0);
        directed_rows[17] = req_row(OP_SAMPLE, 12'd4095, 32'd31, 1'b1, 1'b0);
        directed_rows[18] = req_row(OP_FETCH, 12'd0, 32'd0, 1'b0, 1'b0);
        directed_rows[19] = reg_row(CFG_PRESS_MODE, 32'(MODE_SHORT));
        directed_rows[20] = req_row(OP_SAMPLE, 12'd1, 32'd40, 1'b1, 1'b0);
        directed_rows[21] = req_row(OP_SAMPLE, 12'd2000, 32'd100, 1'b1, 1'b0);
        directed_rows[22] = req_row(OP_SAMPLE, 12'd2000, 32'd100, 1'b1, 1'b0);
        directed_rows[23] = req_row(OP_SAMPLE, 12'd1, 32'd100, 1'b1, 1'b0);
        directed_rows[24] = req_row(OP_FETCH, 12'd0, 32'd0, 1'b0, 1'b0);
        directed_rows[25] = reg_row(CFG_PRESS_PERIOD, 32'hFFFF_FFFF);
        directed_rows[26] = req_row(OP_SAMPLE, 12'd4095, 32'd0, 1'b1, 1'b0);
        directed_rows[27] = req_row(OP_SAMPLE, 12'd1, 32'hFFFF_FFFE, 1'b1, 1'b0);
        directed_rows[28] = req_row(OP_FETCH, 12'd0, 32'd0, 1'b0, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = directed_rows[r];
            if (row.is_cfg)
                set_register(row.idx, row.data);
            else
                send_request(row.op, row.sample, row.now, row.typed, row.flag);
        end

        now_t = '0;
        want_press = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            period = $urandom_range(0, 1) ? PERIOD_W'($urandom_range(0, 300)) : $urandom;
            case (p)
                0: apply_setting(12'd0, 12'd4095, MODE_LONG, PERIOD_W'($urandom_range(0, 300)));
                1: apply_setting(12'd4095, 12'd4095, MODE_SHORT, 32'd50);
                2: apply_setting(12'd0, 12'd0, MODE_LONG, 32'd0);
                3: apply_setting(12'd1000, 12'd2000, MODE_SHORT, 32'hFFFF_FFFF);
                default: apply_setting(SIG_W'($urandom), SIG_W'($urandom),
                                       1'($urandom), period);
            endcase
            calm = (p == 2 || p == 5);
            sent = 0;
            while (sent < PHASE_REQS) begin
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send_request(1'($urandom), SIG_W'($urandom), $urandom, 1'b0, 1'b0);
                    sent++;
                end else if (pick < 25) begin
                    send_request(OP_FETCH, SIG_W'($urandom), $urandom, 1'b0, 1'b0);
                    sent++;
                end else if (pick < 30) begin
                    send_request(OP_SAMPLE, '0, $urandom, 1'b0, 1'b0);
                end else begin
                    if ($urandom_range(0, 99) < 30)
                        want_press = !want_press;
                    case ($urandom_range(0, 3))
                        0: now_t = now_t + $urandom_range(0, 20);
                        1: now_t = start_ms_m + period_m + $urandom_range(0, 4) - 2;
                        2: now_t = start_ms_m + $urandom_range(0, 4);
                        default: now_t = $urandom;
                    endcase
                    send_request(OP_SAMPLE, pick_sample(want_press), now_t, 1'b0, 1'b0);
                    sent++;
                end
            end
        end

        drain_results();
        calm = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && flag_due_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
